// ----- rtl/core/tree_all_pairs_edge_distance_macros.svh -----
// assertion macros used by the checker file of the tree distance block
// no dependencies; each macro expects i_clk and i_rst_n in scope
`ifndef TREE_ALL_PAIRS_EDGE_DISTANCE_MACROS_SVH
`define TREE_ALL_PAIRS_EDGE_DISTANCE_MACROS_SVH

// same-cycle implication, off during reset
`define TAPD_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define TAPD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/tapd_pkg.sv -----
// shared types, codes and helpers for the tree distance block
// no dependencies
package tapd_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] OP_FIRST = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [7:0] EDGE_LIMIT = 8'd255;

    typedef enum logic [1:0] {
        K_NOP,
        K_QUERY,
        K_START,
        K_EDGE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] node_a;
        logic [7:0] node_b;
    } t_cmd;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

endpackage

// ----- rtl/core/tapd_front.sv -----
// front end: range check and classification of input beats into commands
// depends on tapd_pkg
module tapd_front import tapd_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic [1:0] i_op,
    input  logic [7:0] i_node_a,
    input  logic [7:0] i_node_b,
    output t_cmd       o_cmd
);

    logic w_in_range;

    assign w_in_range = (32'(i_node_a) < MAX_NODES) && (32'(i_node_b) < MAX_NODES);

    always_comb begin
        o_cmd.node_a = i_node_a;
        o_cmd.node_b = i_node_b;
        o_cmd.kind   = K_NOP;
        if (w_in_range) begin
            case (i_op)
                OP_FIRST: o_cmd.kind = K_START;
                OP_EDGE:  o_cmd.kind = K_EDGE;
                OP_QUERY: o_cmd.kind = K_QUERY;
                default:  o_cmd.kind = K_NOP;
            endcase
        end
    end

endmodule

// ----- rtl/core/tapd_fifo.sv -----
// short command queue between front and back end
// depends on tapd_pkg
module tapd_fifo import tapd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd              r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full)
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (i_pop && !o_empty)
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

endmodule

// ----- rtl/core/tapd_back.sv -----
// back end: sequencer that walks earlier edges and updates the distance table
// depends on tapd_pkg; holds the distance table and edge child memories
module tapd_back import tapd_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_distance,
    output logic       o_order_error
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int TD = 2 ** (2 * NW);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_QOUT, S_WR1, S_WR2, S_LOOP, S_CHRD, S_CHCK,
        S_TW1, S_TW2, S_RTCHK, S_RTW1, S_RTW2, S_FIN, S_OUT
    } t_state;

    logic [7:0]      r_tbl [TD];
    logic [7:0]      r_ch  [256];

    t_state          r_state, n_state;
    t_kind           r_kind, n_kind;
    logic [7:0]      r_a, n_a, r_b, n_b, r_e, n_e;
    logic [7:0]      r_root, n_root, r_cnt, n_cnt, r_j, n_j, r_sum, n_sum;
    logic [7:0]      r_dist, n_dist;
    logic            r_err, n_err, r_start, n_start;
    logic            r_valid, n_valid;

    logic [7:0]      r_tq, r_chq;
    logic [2*NW-1:0] w_traddr, w_twaddr;
    logic            w_twe;
    logic [7:0]      w_twdata;
    logic [7:0]      w_chraddr, w_chwaddr, w_chwdata;
    logic            w_chwe;

    function automatic logic [2*NW-1:0] taddr(input logic [7:0] x, input logic [7:0] y);
        return {NW'(x), NW'(y)};
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_twe) r_tbl[w_twaddr] <= w_twdata;
        r_tq <= r_tbl[w_traddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_chwe) r_ch[w_chwaddr] <= w_chwdata;
        r_chq <= r_ch[w_chraddr];
    end

    assign o_pop         = (r_state == S_IDLE) && !i_q_empty && !r_valid;
    assign o_valid       = r_valid;
    assign o_distance    = r_dist;
    assign o_order_error = r_err;

    always_comb begin
        n_state = r_state; n_kind = r_kind; n_a = r_a; n_b = r_b; n_e = r_e;
        n_root = r_root; n_cnt = r_cnt; n_j = r_j; n_sum = r_sum;
        n_dist = r_dist; n_err = r_err; n_start = r_start;
        n_valid = r_valid && !i_ready;
        w_traddr = taddr(r_a, r_b);
        w_twe = 1'b0; w_twaddr = taddr(r_a, r_b); w_twdata = 8'd1;
        w_chraddr = r_j - 8'd1;
        w_chwe = 1'b0; w_chwaddr = r_cnt; w_chwdata = r_b;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_kind = i_cmd.kind; n_a = i_cmd.node_a; n_b = i_cmd.node_b;
                    n_dist = 8'd0; n_err = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_kind)
                    K_QUERY: n_state = (r_a == r_b) ? S_OUT : S_QOUT;
                    K_START: begin n_start = 1'b1; n_state = S_WR1; end
                    K_EDGE: begin
                        if (r_cnt == 8'd0) begin
                            n_start = 1'b1; n_state = S_WR1;
                        end else if (r_cnt == EDGE_LIMIT) begin
                            n_state = S_OUT;
                        end else begin
                            n_start = 1'b0; n_state = S_WR1;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_QOUT: begin n_dist = r_tq; n_state = S_OUT; end
            S_WR1: begin w_twe = 1'b1; n_state = S_WR2; end
            S_WR2: begin
                w_twe = 1'b1; w_twaddr = taddr(r_b, r_a);
                if (r_start) begin
                    w_chwe = 1'b1; w_chwaddr = 8'd0;
                    n_root = r_a; n_cnt = 8'd1; n_state = S_OUT;
                end else begin
                    n_j = r_cnt; n_state = S_LOOP;
                end
            end
            S_LOOP: n_state = (r_j == 8'd0) ? S_RTCHK : S_CHRD;
            S_CHRD: begin n_j = r_j - 8'd1; n_state = S_CHCK; end
            S_CHCK: begin
                n_e = r_chq;
                w_traddr = taddr(r_a, r_chq);
                n_state = (r_chq == r_a) ? S_LOOP : S_TW1;
            end
            S_TW1: begin
                n_sum = sat_inc(r_tq);
                w_twe = 1'b1; w_twaddr = taddr(r_e, r_b); w_twdata = sat_inc(r_tq);
                n_state = S_TW2;
            end
            S_TW2: begin
                w_twe = 1'b1; w_twaddr = taddr(r_b, r_e); w_twdata = r_sum;
                n_state = S_LOOP;
            end
            S_RTCHK: begin
                w_traddr = taddr(r_a, r_root);
                if (r_a != r_root) begin
                    n_err = (r_a < r_root); n_state = S_RTW1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RTW1: begin
                n_sum = sat_inc(r_tq);
                w_twe = 1'b1; w_twaddr = taddr(r_b, r_root); w_twdata = sat_inc(r_tq);
                n_state = S_RTW2;
            end
            S_RTW2: begin
                w_twe = 1'b1; w_twaddr = taddr(r_root, r_b); w_twdata = r_sum;
                n_state = S_FIN;
            end
            S_FIN: begin
                w_chwe = 1'b1;
                n_cnt = r_cnt + 8'd1; n_state = S_OUT;
            end
            S_OUT: begin n_valid = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_root  <= 8'd0;
            r_cnt   <= 8'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_kind <= n_kind; r_a <= n_a; r_b <= n_b; r_e <= n_e; r_j <= n_j;
        r_sum <= n_sum; r_dist <= n_dist; r_err <= n_err; r_start <= n_start;
    end

endmodule

// ----- rtl/core/tree_all_pairs_edge_distance.sv -----
// top level of the rooted tree all-pairs path length block
// depends on tapd_pkg, tapd_front, tapd_fifo, tapd_back
//
// input stream: one beat per item; tuser carries the op (first edge, further
// edge, distance query), tdata the two node numbers. output stream: exactly
// one beat per input beat, in order; tdata is the distance, tuser the order
// error flag.
// a further edge walks every earlier edge child and then the root; each
// earlier edge costs one read and two writes of the distance table, which
// has a single write port.
// a two-entry command queue lets input beats be taken while the back end is
// busy or the output beat waits; a stalled receiver holds the output
// register and, once the queue fills, tready drops.
// reset clears root, edge count, queue and output valid; table and edge
// child memories are not cleared, so only pairs written by a loaded tree may
// be queried.
module tree_all_pairs_edge_distance import tapd_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // node_a [7:0], node_b [15:8]
    input  logic [1:0]  s_axis_tuser,  // op [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // distance [7:0]
    output logic        m_axis_tuser   // order_error [0]
);

    t_cmd w_cmd_in, w_cmd_out;
    logic w_full, w_empty, w_pop;

    tapd_front #(.MAX_NODES(MAX_NODES)) u_front (
        .i_op     (s_axis_tuser),
        .i_node_a (s_axis_tdata[7:0]),
        .i_node_b (s_axis_tdata[15:8]),
        .o_cmd    (w_cmd_in)
    );

    tapd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_cmd_out)
    );

    assign s_axis_tready = !w_full;

    tapd_back #(.MAX_NODES(MAX_NODES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_empty),
        .i_cmd         (w_cmd_out),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_distance    (m_axis_tdata),
        .o_order_error (m_axis_tuser)
    );

endmodule

// ----- rtl/core/tapd_checker.sv -----
// port-level checks for the tree distance block, bound to the top level
// depends on tree_all_pairs_edge_distance_macros.svh
`include "tree_all_pairs_edge_distance_macros.svh"

module tapd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // output beat holds while stalled
    `TAPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // an edge beat never carries a distance together with the error flag
    `TAPD_ASSERT_NOW(a_err_dist, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'd0)
    // a taken output beat is not followed at once by another one
    `TAPD_ASSERT_NEXT(a_out_gap, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
    // a stalled output beat keeps its payload
    `TAPD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind tree_all_pairs_edge_distance tapd_checker u_tapd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
